>>> rtl/sha512_pkg.sv
// Package for the SHA-512/SHA-384 hash block: state codes, initial values,
// round constants and the rotate-right helper function. No dependencies.
package sha512_pkg;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ROUND,
      ST_FOLD,
      ST_PAD,
      ST_OUT
   } state_type;

   typedef struct packed {
      logic start;
      logic busy;
      logic done;
   } core_ctl_type;

   localparam logic [63:0] INIT_512 [8] = '{
      64'h6a09e667f3bcc908, 64'hbb67ae8584caa73b, 64'h3c6ef372fe94f82b, 64'ha54ff53a5f1d36f1,
      64'h510e527fade682d1, 64'h9b05688c2b3e6c1f, 64'h1f83d9abfb41bd6b, 64'h5be0cd19137e2179};

   localparam logic [63:0] INIT_384 [8] = '{
      64'hcbbb9d5dc1059ed8, 64'h629a292a367cd507, 64'h9159015a3070dd17, 64'h152fecd8f70e5939,
      64'h67332667ffc00b31, 64'h8eb44a8768581511, 64'hdb0c2e0d64f98fa7, 64'h47b5481dbefa4fa4};

   localparam logic [63:0] ROUND_K [80] = '{
      64'h428a2f98d728ae22, 64'h7137449123ef65cd, 64'hb5c0fbcfec4d3b2f, 64'he9b5dba58189dbbc,
      64'h3956c25bf348b538, 64'h59f111f1b605d019, 64'h923f82a4af194f9b, 64'hab1c5ed5da6d8118,
      64'hd807aa98a3030242, 64'h12835b0145706fbe, 64'h243185be4ee4b28c, 64'h550c7dc3d5ffb4e2,
      64'h72be5d74f27b896f, 64'h80deb1fe3b1696b1, 64'h9bdc06a725c71235, 64'hc19bf174cf692694,
      64'he49b69c19ef14ad2, 64'hefbe4786384f25e3, 64'h0fc19dc68b8cd5b5, 64'h240ca1cc77ac9c65,
      64'h2de92c6f592b0275, 64'h4a7484aa6ea6e483, 64'h5cb0a9dcbd41fbd4, 64'h76f988da831153b5,
      64'h983e5152ee66dfab, 64'ha831c66d2db43210, 64'hb00327c898fb213f, 64'hbf597fc7beef0ee4,
      64'hc6e00bf33da88fc2, 64'hd5a79147930aa725, 64'h06ca6351e003826f, 64'h142929670a0e6e70,
      64'h27b70a8546d22ffc, 64'h2e1b21385c26c926, 64'h4d2c6dfc5ac42aed, 64'h53380d139d95b3df,
      64'h650a73548baf63de, 64'h766a0abb3c77b2a8, 64'h81c2c92e47edaee6, 64'h92722c851482353b,
      64'ha2bfe8a14cf10364, 64'ha81a664bbc423001, 64'hc24b8b70d0f89791, 64'hc76c51a30654be30,
      64'hd192e819d6ef5218, 64'hd69906245565a910, 64'hf40e35855771202a, 64'h106aa07032bbd1b8,
      64'h19a4c116b8d2d0c8, 64'h1e376c085141ab53, 64'h2748774cdf8eeb99, 64'h34b0bcb5e19b48a8,
      64'h391c0cb3c5c95a63, 64'h4ed8aa4ae3418acb, 64'h5b9cca4f7763e373, 64'h682e6ff3d6b2b8a3,
      64'h748f82ee5defb2fc, 64'h78a5636f43172f60, 64'h84c87814a1f0ab72, 64'h8cc702081a6439ec,
      64'h90befffa23631e28, 64'ha4506cebde82bde9, 64'hbef9a3f7b2c67915, 64'hc67178f2e372532b,
      64'hca273eceea26619c, 64'hd186b8c721c0c207, 64'heada7dd6cde0eb1e, 64'hf57d4f7fee6ed178,
      64'h06f067aa72176fba, 64'h0a637dc5a2c898a6, 64'h113f9804bef90dae, 64'h1b710b35131c471b,
      64'h28db77f523047d84, 64'h32caab7b40c72493, 64'h3c9ebe0a15c9bebc, 64'h431d67c49c100d4c,
      64'h4cc5d4becb3e42b6, 64'h597f299cfc657e2a, 64'h5fcb6fab3ad6faec, 64'h6c44198c4a475817};

   function automatic logic [63:0] rotr(input logic [63:0] x, input int n);
      rotr = (x >> n) | (x << (64 - n));
   endfunction

endpackage

>>> rtl/sha512_sha384_hash.sv
// Top level of the SHA-512/SHA-384 hash block: input buffer, padding
// sequencer and digest output. Depends on sha512_pkg and sha512_core.
//
// One message word is taken per cycle while the 16-word block fills; each full
// block then holds off input while the shared round unit is loaded, runs its 80
// rounds, sees the end and folds the result into the hash.
// A last word adds padding of up to two blocks, then the digest words leave one
// per accepted result item; the block takes new input after the final one.
module sha512_sha384_hash
   import sha512_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [63:0] req_data_word,
   input  logic [3:0]  req_valid_bytes,
   input  logic        req_last_word,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [63:0] rsp_digest_word,
   output logic        rsp_last_digest,
   input  logic        csr_write,
   input  logic        csr_data
);

   state_type    state_ff, state_in;
   logic         variant_ff;
   logic [63:0]  hash_ff [8];
   logic [63:0]  blk_ff [16];
   logic [3:0]   pos_ff;
   logic [63:0]  bytes_ff;
   logic         padding_ff;   // padding in progress
   logic         final_ff;     // after this compress, emit
   logic         pend_ff;      // 0x80 still to be placed
   logic [2:0]   oidx_ff;
   logic [63:0]  vout [8];
   core_ctl_type ctl;
   logic         start;
   logic         start_ff;
   logic [63:0]  pad_word;
   logic [3:0]   nv;
   logic [63:0]  bytes_sum;
   logic [2:0]   last_idx;

   sha512_core u_core (
      .clock(clock), .reset(reset), .start(start_ff), .blk(blk_ff),
      .hin(hash_ff), .vout(vout), .ctl(ctl)
   );

   assign nv = (req_valid_bytes > 4'd8) ? 4'd8 : req_valid_bytes;
   assign last_idx = variant_ff ? 3'd5 : 3'd7;
   assign req_ready = (state_ff == ST_IDLE) && !csr_write;
   assign rsp_valid = (state_ff == ST_OUT);
   assign rsp_digest_word = hash_ff[oidx_ff];
   assign rsp_last_digest = (oidx_ff == last_idx);

   always_comb begin
      logic [63:0] mask;
      mask = (nv == 4'd0) ? 64'd0 : ~(64'hffffffffffffffff >> {nv, 3'b000});
      bytes_sum = bytes_ff + (req_last_word ? {60'd0, nv} : 64'd8);
      pad_word = (req_data_word & mask) | (64'h8000000000000000 >> {nv, 3'b000});
   end

   always_comb begin
      state_in = state_ff;
      start = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid && req_ready) begin
               if (pos_ff == 4'd15) begin
                  state_in = ST_ROUND;
                  start = 1'b1;
               end else if (req_last_word) state_in = ST_PAD;
            end
         end
         ST_ROUND: if (ctl.done) state_in = ST_FOLD;
         ST_FOLD: state_in = final_ff ? ST_OUT : (padding_ff ? ST_PAD : ST_IDLE);
         ST_PAD: begin
            if (pos_ff == 4'd0 && !padding_ff && pend_ff == 1'b0 && final_ff) begin
               state_in = ST_ROUND;
               start = 1'b1;
            end else if (pos_ff == 4'd15) begin
               state_in = ST_ROUND;
               start = 1'b1;
            end
         end
         ST_OUT: if (rsp_ready && rsp_last_digest) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else if (csr_write) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         start_ff <= 1'b0;
      end else begin
         start_ff <= start;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || csr_write) begin
         variant_ff <= reset ? 1'b0 : csr_data;
         for (int i = 0; i < 8; i++)
            hash_ff[i] <= (!reset && csr_data) ? INIT_384[i] : INIT_512[i];
         pos_ff <= '0;
         bytes_ff <= '0;
         padding_ff <= 1'b0;
         final_ff <= 1'b0;
         pend_ff <= 1'b0;
         oidx_ff <= '0;
      end else begin
         unique case (state_ff)
            ST_IDLE: if (req_valid && req_ready) begin
               bytes_ff <= bytes_sum;
               blk_ff[pos_ff] <= req_last_word ? ((nv == 4'd8) ? req_data_word : pad_word)
                                               : req_data_word;
               pos_ff <= pos_ff + 4'd1;
               if (req_last_word) begin
                  padding_ff <= 1'b1;
                  pend_ff <= (nv == 4'd8);
                  final_ff <= 1'b0;
               end
            end
            ST_PAD: begin
               if (pend_ff) begin
                  blk_ff[pos_ff] <= 64'h8000000000000000;
                  pend_ff <= 1'b0;
                  pos_ff <= pos_ff + 4'd1;
               end else if (!final_ff && pos_ff == 4'd0 && !padding_ff) begin
                  pos_ff <= pos_ff;
               end else if (pos_ff == 4'd14 && !final_ff) begin
                  blk_ff[14] <= {61'd0, bytes_ff[63:61]};
                  pos_ff <= 4'd15;
                  final_ff <= 1'b1;
               end else if (pos_ff == 4'd15 && final_ff) begin
                  blk_ff[15] <= {bytes_ff[60:0], 3'b000};
                  pos_ff <= 4'd0;
                  padding_ff <= 1'b0;
               end else begin
                  blk_ff[pos_ff] <= 64'd0;
                  pos_ff <= pos_ff + 4'd1;
               end
            end
            ST_FOLD: begin
               for (int i = 0; i < 8; i++) hash_ff[i] <= hash_ff[i] + vout[i];
               oidx_ff <= '0;
            end
            ST_OUT: if (rsp_ready) begin
               if (rsp_last_digest) begin
                  for (int i = 0; i < 8; i++)
                     hash_ff[i] <= variant_ff ? INIT_384[i] : INIT_512[i];
                  pos_ff <= '0;
                  bytes_ff <= '0;
                  final_ff <= 1'b0;
                  padding_ff <= 1'b0;
               end
               oidx_ff <= oidx_ff + 3'd1;
            end
            default: ;
         endcase
      end
   end

   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      ctl.busy |-> !req_ready) else $error("input accepted during rounds");
   a_out_idx: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> oidx_ff <= last_idx) else $error("digest index overrun");
   a_last_back: assert property (@(posedge clock) disable iff (reset || csr_write)
      rsp_valid && rsp_ready && rsp_last_digest |=> state_ff == ST_IDLE)
      else $error("no return to idle after digest");

endmodule

>>> rtl/sha512_core.sv
// One SHA-512 round per cycle for 80 rounds, with a rolling 16-word schedule.
// Depends on sha512_pkg.
module sha512_core
   import sha512_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic [63:0]        blk [16],
   input  logic [63:0]        hin [8],
   output logic [63:0]        vout [8],
   output core_ctl_type       ctl
);

   logic [63:0] w_ff [16];
   logic [63:0] v_ff [8];
   logic [6:0]  rnd_ff;
   logic        busy_ff;
   logic        done_ff;
   logic [63:0] wnew, t1, t2, s0, s1, wr;

   always_comb begin
      s1 = rotr(w_ff[14], 19) ^ rotr(w_ff[14], 61) ^ (w_ff[14] >> 6);
      s0 = rotr(w_ff[1], 1) ^ rotr(w_ff[1], 8) ^ (w_ff[1] >> 7);
      wnew = s1 + w_ff[9] + s0 + w_ff[0];
      wr = w_ff[0];
      t1 = v_ff[7] + (rotr(v_ff[4], 14) ^ rotr(v_ff[4], 18) ^ rotr(v_ff[4], 41))
         + ((v_ff[4] & v_ff[5]) ^ (~v_ff[4] & v_ff[6])) + ROUND_K[rnd_ff] + wr;
      t2 = (rotr(v_ff[0], 28) ^ rotr(v_ff[0], 34) ^ rotr(v_ff[0], 39))
         + ((v_ff[0] & v_ff[1]) ^ (v_ff[0] & v_ff[2]) ^ (v_ff[1] & v_ff[2]));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         rnd_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            rnd_ff  <= '0;
         end else if (busy_ff) begin
            if (rnd_ff == 7'd79) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
            rnd_ff <= rnd_ff + 7'd1;
         end
      end
   end

   // window: w_ff[0] is the current word, shift one per round
   always_ff @(posedge clock) begin
      if (start) begin
         w_ff <= blk;
         v_ff <= hin;
      end else if (busy_ff) begin
         for (int i = 0; i < 15; i++) w_ff[i] <= w_ff[i+1];
         w_ff[15] <= wnew;
         v_ff[7] <= v_ff[6];
         v_ff[6] <= v_ff[5];
         v_ff[5] <= v_ff[4];
         v_ff[4] <= v_ff[3] + t1;
         v_ff[3] <= v_ff[2];
         v_ff[2] <= v_ff[1];
         v_ff[1] <= v_ff[0];
         v_ff[0] <= t1 + t2;
      end
   end

   assign vout = v_ff;
   assign ctl.start = start;
   assign ctl.busy = busy_ff;
   assign ctl.done = done_ff;

   a_no_restart: assert property (@(posedge clock) disable iff (reset)
      busy_ff && rnd_ff != 7'd79 |=> busy_ff) else $error("round loop stopped early");
   a_done_end: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> !busy_ff) else $error("done while busy");
   a_done_after: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> $past(busy_ff)) else $error("done without rounds");

endmodule

>>> sim/tb_top.sv
// Self-checking testbench for sha512_sha384_hash: drives messages and variant
// writes, predicts every digest word in-bench and checks each result item.
// Depends on the RTL top level and sha512_pkg only through the DUT ports.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [63:0] RND_K [0:79] = '{
      64'h428a2f98d728ae22, 64'h7137449123ef65cd, 64'hb5c0fbcfec4d3b2f, 64'he9b5dba58189dbbc,
      64'h3956c25bf348b538, 64'h59f111f1b605d019, 64'h923f82a4af194f9b, 64'hab1c5ed5da6d8118,
      64'hd807aa98a3030242, 64'h12835b0145706fbe, 64'h243185be4ee4b28c, 64'h550c7dc3d5ffb4e2,
      64'h72be5d74f27b896f, 64'h80deb1fe3b1696b1, 64'h9bdc06a725c71235, 64'hc19bf174cf692694,
      64'he49b69c19ef14ad2, 64'hefbe4786384f25e3, 64'h0fc19dc68b8cd5b5, 64'h240ca1cc77ac9c65,
      64'h2de92c6f592b0275, 64'h4a7484aa6ea6e483, 64'h5cb0a9dcbd41fbd4, 64'h76f988da831153b5,
      64'h983e5152ee66dfab, 64'ha831c66d2db43210, 64'hb00327c898fb213f, 64'hbf597fc7beef0ee4,
      64'hc6e00bf33da88fc2, 64'hd5a79147930aa725, 64'h06ca6351e003826f, 64'h142929670a0e6e70,
      64'h27b70a8546d22ffc, 64'h2e1b21385c26c926, 64'h4d2c6dfc5ac42aed, 64'h53380d139d95b3df,
      64'h650a73548baf63de, 64'h766a0abb3c77b2a8, 64'h81c2c92e47edaee6, 64'h92722c851482353b,
      64'ha2bfe8a14cf10364, 64'ha81a664bbc423001, 64'hc24b8b70d0f89791, 64'hc76c51a30654be30,
      64'hd192e819d6ef5218, 64'hd69906245565a910, 64'hf40e35855771202a, 64'h106aa07032bbd1b8,
      64'h19a4c116b8d2d0c8, 64'h1e376c085141ab53, 64'h2748774cdf8eeb99, 64'h34b0bcb5e19b48a8,
      64'h391c0cb3c5c95a63, 64'h4ed8aa4ae3418acb, 64'h5b9cca4f7763e373, 64'h682e6ff3d6b2b8a3,
      64'h748f82ee5defb2fc, 64'h78a5636f43172f60, 64'h84c87814a1f0ab72, 64'h8cc702081a6439ec,
      64'h90befffa23631e28, 64'ha4506cebde82bde9, 64'hbef9a3f7b2c67915, 64'hc67178f2e372532b,
      64'hca273eceea26619c, 64'hd186b8c721c0c207, 64'heada7dd6cde0eb1e, 64'hf57d4f7fee6ed178,
      64'h06f067aa72176fba, 64'h0a637dc5a2c898a6, 64'h113f9804bef90dae, 64'h1b710b35131c471b,
      64'h28db77f523047d84, 64'h32caab7b40c72493, 64'h3c9ebe0a15c9bebc, 64'h431d67c49c100d4c,
      64'h4cc5d4becb3e42b6, 64'h597f299cfc657e2a, 64'h5fcb6fab3ad6faec, 64'h6c44198c4a475817};

   localparam logic [63:0] IV_512 [0:7] = '{
      64'h6a09e667f3bcc908, 64'hbb67ae8584caa73b, 64'h3c6ef372fe94f82b, 64'ha54ff53a5f1d36f1,
      64'h510e527fade682d1, 64'h9b05688c2b3e6c1f, 64'h1f83d9abfb41bd6b, 64'h5be0cd19137e2179};

   localparam logic [63:0] IV_384 [0:7] = '{
      64'hcbbb9d5dc1059ed8, 64'h629a292a367cd507, 64'h9159015a3070dd17, 64'h152fecd8f70e5939,
      64'h67332667ffc00b31, 64'h8eb44a8768581511, 64'hdb0c2e0d64f98fa7, 64'h47b5481dbefa4fa4};

   typedef struct {
      logic [63:0] word;
      logic        last;
   } digest_item_type;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic [63:0] req_data_word;
   logic [3:0]  req_valid_bytes;
   logic        req_last_word;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [63:0] rsp_digest_word;
   logic        rsp_last_digest;
   logic        csr_write;
   logic        csr_data;

   // predictor state
   logic        sha384_mode;
   logic [63:0] chain [0:7];
   logic [63:0] sched [0:15];
   logic [3:0]  fill_pos;
   logic [63:0] byte_count;

   digest_item_type digest_q [$];
   int          errors;
   int          items_sent;
   int          messages_sent;
   int          digests_seen;
   bit          tx_idle_en;
   bit          rx_idle_en;
   bit          rx_long_hold;
   int          rx_hold_left;

   sha512_sha384_hash dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_data_word   (req_data_word),
      .req_valid_bytes (req_valid_bytes),
      .req_last_word   (req_last_word),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_digest_word (rsp_digest_word),
      .rsp_last_digest (rsp_last_digest),
      .csr_write       (csr_write),
      .csr_data        (csr_data)
   );

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   function automatic logic [63:0] ror64(input logic [63:0] x, input int n);
      return (x >> n) | (x << (64 - n));
   endfunction

   task automatic load_iv();
      for (int i = 0; i < 8; i++) begin
         chain[i] = sha384_mode ? IV_384[i] : IV_512[i];
      end
      fill_pos = '0;
      byte_count = '0;
   endtask

   task automatic compress_block();
      logic [63:0] v [0:7];
      logic [63:0] w, w2, w15, t1, t2;
      for (int i = 0; i < 8; i++) begin
         v[i] = chain[i];
      end
      for (int r = 0; r < 80; r++) begin
         if (r < 16) begin
            w = sched[r];
         end else begin
            w2 = sched[(r - 2) & 15];
            w15 = sched[(r - 15) & 15];
            w = (ror64(w2, 19) ^ ror64(w2, 61) ^ (w2 >> 6)) + sched[(r - 7) & 15]
               + (ror64(w15, 1) ^ ror64(w15, 8) ^ (w15 >> 7)) + sched[r & 15];
            sched[r & 15] = w;
         end
         t1 = v[7] + (ror64(v[4], 14) ^ ror64(v[4], 18) ^ ror64(v[4], 41))
            + ((v[4] & v[5]) ^ (~v[4] & v[6])) + RND_K[r] + w;
         t2 = (ror64(v[0], 28) ^ ror64(v[0], 34) ^ ror64(v[0], 39))
            + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
         v[7] = v[6];
         v[6] = v[5];
         v[5] = v[4];
         v[4] = v[3] + t1;
         v[3] = v[2];
         v[2] = v[1];
         v[1] = v[0];
         v[0] = t1 + t2;
      end
      for (int i = 0; i < 8; i++) begin
         chain[i] = chain[i] + v[i];
      end
   endtask

   task automatic append_word(input logic [63:0] w);
      sched[fill_pos] = w;
      fill_pos = fill_pos + 4'd1;
      if (fill_pos == 4'd0) begin
         compress_block();
      end
   endtask

   task automatic absorb_item(input logic [63:0] data, input logic [3:0] vb, input logic last);
      int          nv;
      int          sh;
      int          count;
      logic [63:0] keep;
      logic [63:0] hi_len;
      logic [63:0] lo_len;
      digest_item_type d;
      if (!last) begin
         byte_count = byte_count + 64'd8;
         append_word(data);
         return;
      end
      nv = (vb > 4'd8) ? 8 : int'(vb);
      byte_count = byte_count + 64'(nv);
      if (nv == 8) begin
         append_word(data);
         append_word(64'h8000000000000000);
      end else begin
         sh = 64 - 8 * nv;
         keep = (nv == 0) ? 64'd0 : ((data >> sh) << sh);
         append_word(keep | (64'h80 << (sh - 8)));
      end
      hi_len = byte_count >> 61;
      lo_len = byte_count << 3;
      if (fill_pos > 4'd14) begin
         while (fill_pos != 4'd0) begin
            append_word(64'd0);
         end
      end
      while (fill_pos < 4'd14) begin
         append_word(64'd0);
      end
      append_word(hi_len);
      append_word(lo_len);
      count = sha384_mode ? 6 : 8;
      for (int i = 0; i < count; i++) begin
         d.word = chain[i];
         d.last = (i + 1 == count);
         digest_q.push_back(d);
      end
      load_iv();
      messages_sent++;
   endtask

   // one input item; called and returns at a rising edge
   task automatic send_item(input logic [63:0] data, input logic [3:0] vb, input logic last);
      int gap;
      gap = (tx_idle_en && $urandom_range(0, 3) == 0) ? $urandom_range(1, 8) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data_word <= data;
      req_valid_bytes <= vb;
      req_last_word <= last;
      do @(posedge clock); while (!req_ready);
      absorb_item(data, vb, last);
      items_sent++;
   endtask

   function automatic logic [63:0] rand_word();
      return {$urandom, $urandom};
   endfunction

   task automatic send_message(input int len, input logic [3:0] last_vb);
      for (int i = 0; i < len; i++) begin
         send_item(rand_word(), 4'($urandom_range(0, 15)), 1'b0);
      end
      send_item(rand_word(), last_vb, 1'b1);
   endtask

   // drop valid and wait until every expected digest word is out
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (digest_q.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic write_variant(input logic v);
      drain();
      csr_write <= 1'b1;
      csr_data <= v;
      @(posedge clock);
      csr_write <= 1'b0;
      sha384_mode = v;
      load_iv();
      @(posedge clock);
   endtask

   always @(posedge clock) begin
      if (rsp_valid && rsp_ready) begin
         digests_seen++;
         if (digest_q.size() == 0) begin
            errors++;
            $display("%0t: unexpected digest word %h last %b", $time,
               rsp_digest_word, rsp_last_digest);
         end else begin
            automatic digest_item_type exp_d = digest_q.pop_front();
            if (rsp_digest_word !== exp_d.word) begin
               errors++;
               $display("%0t: digest_word expected %h actual %h", $time,
                  exp_d.word, rsp_digest_word);
            end
            if (rsp_last_digest !== exp_d.last) begin
               errors++;
               $display("%0t: last_digest expected %b actual %b", $time,
                  exp_d.last, rsp_last_digest);
            end
         end
      end
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (rx_hold_left > 0) begin
         rx_hold_left--;
         rsp_ready <= 1'b0;
      end else if (rx_long_hold) begin
         rx_long_hold = 1'b0;
         rx_hold_left = 400;
         rsp_ready <= 1'b0;
      end else if (rx_idle_en && $urandom_range(0, 5) == 0) begin
         rx_hold_left = $urandom_range(0, 7);
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   task automatic test_directed();
      send_item(rand_word(), 4'd0, 1'b1);
      send_item(64'hffffffffffffffff, 4'd8, 1'b1);
      send_item(64'hffffffffffffffff, 4'd15, 1'b1);
      send_item(64'h0, 4'd9, 1'b0);
      send_item(64'hffffffffffffffff, 4'd0, 1'b1);
      send_item(64'hffffffffffffffff, 4'd4, 1'b1);
      send_item(64'h0123456789abcdef, 4'd1, 1'b1);
      send_item(64'hfedcba9876543210, 4'd7, 1'b1);
      write_variant(1'b1);
      send_item(64'h0, 4'd0, 1'b1);
      send_item(64'hffffffffffffffff, 4'd8, 1'b1);
      send_message(13, 4'd8);
   endtask

   task automatic test_backpressure();
      drain();
      rx_long_hold = 1'b1;
      for (int m = 0; m < 3; m++) begin
         send_message($urandom_range(0, 3), 4'($urandom_range(0, 8)));
      end
      drain();
   endtask

   task automatic test_random(input int n_items);
      int target;
      int len;
      target = items_sent + n_items;
      while (items_sent < target) begin
         if ($urandom_range(0, 9) == 0) begin
            write_variant(1'($urandom_range(0, 1)));
         end
         case ($urandom_range(0, 9))
            0: len = $urandom_range(28, 34);
            1, 2: len = $urandom_range(13, 17);
            default: len = $urandom_range(0, 6);
         endcase
         send_message(len, 4'($urandom_range(0, 15)));
      end
   endtask

   task automatic timeout_guard();
      #5ms;
      $display("Some tests failed");
      $finish;
   endtask

   initial begin
      timeout_guard();
   end

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_data_word = '0;
      req_valid_bytes = '0;
      req_last_word = 1'b0;
      csr_write = 1'b0;
      csr_data = 1'b0;
      rsp_ready = 1'b0;
      errors = 0;
      items_sent = 0;
      messages_sent = 0;
      digests_seen = 0;
      tx_idle_en = 1'b1;
      rx_idle_en = 1'b1;
      rx_long_hold = 1'b0;
      rx_hold_left = 0;
      sha384_mode = 1'b0;
      for (int i = 0; i < 16; i++) begin
         sched[i] = '0;
      end
      load_iv();
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed();
      test_backpressure();
      write_variant(1'b0);
      test_random(150);
      write_variant(1'b1);
      test_random(120);
      tx_idle_en = 1'b0;
      rx_idle_en = 1'b0;
      test_random(40);
      drain();
      repeat (100) @(posedge clock);

      $display("Sent %0d items in %0d messages, checked %0d digest words.",
         items_sent, messages_sent, digests_seen);
      $display("Covered both variants, all valid byte counts and block boundaries.");
      if (errors == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end
endmodule
